### design/erot_pkg.sv
package erot_pkg;

  localparam int CoordW   = 24;
  localparam int WorkW    = 26;
  localparam int TrigW    = 32;
  localparam int ZW       = 33;
  localparam int AngleW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int Steps    = 30;
  localparam int ProdW    = TrigW + WorkW;
  localparam int SumW     = ProdW + 1;
  localparam int FracW    = 30;

  localparam logic signed [TrigW-1:0] CORDIC_GAIN = 32'sd652032875;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [WorkW-1:0]  work_t;
  typedef logic        [AngleW-1:0] angle_t;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_ROLL     = 3'd3,
    REG_PITCH    = 3'd4,
    REG_YAW      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_LOAD,
    TRIG_RUN
  } trig_state_t;

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } trig_t;

  typedef struct packed {
    logic  valid;
    logic  op;
    work_t x;
    work_t y;
    work_t z;
  } stage_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458908;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### design/erot_trig.sv
module erot_trig (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    restart,
  input  erot_pkg::angle_t [2:0]  angle,
  output erot_pkg::trig_t  [2:0]  trig,
  output logic                    busy
);
  import erot_pkg::*;

  trig_state_t             state;
  trig_state_t             state_next;
  logic [1:0]              idx;
  logic [4:0]              step;
  logic signed [TrigW-1:0] cx;
  logic signed [TrigW-1:0] cy;
  logic signed [ZW-1:0]    cz;
  logic signed [TrigW-1:0] dx;
  logic signed [TrigW-1:0] dy;
  logic signed [TrigW-1:0] x_next;
  logic signed [TrigW-1:0] y_next;
  logic signed [ZW-1:0]    z_next;
  logic signed [ZW-1:0]    atan_z;
  angle_t                  cur;
  logic                    last_step;

  assign cur       = angle[idx];
  assign last_step = (step == 5'(Steps - 1));
  assign busy      = (state != TRIG_IDLE);

  // one cordic micro-rotation
  always_comb begin
    dx     = cy >>> step;
    dy     = cx >>> step;
    atan_z = ZW'(atan_turn(step));
    if (!cz[ZW-1]) begin
      x_next = cx - dx;
      y_next = cy + dy;
      z_next = cz - atan_z;
    end else begin
      x_next = cx + dx;
      y_next = cy - dy;
      z_next = cz + atan_z;
    end
  end

  // sequencer: three angles one after another
  always_comb begin
    state_next = state;
    case (state)
      TRIG_IDLE: state_next = TRIG_IDLE;
      TRIG_LOAD: state_next = TRIG_RUN;
      TRIG_RUN: begin
        if (last_step) begin
          state_next = (idx == 2'd2) ? TRIG_IDLE : TRIG_LOAD;
        end
      end
      default: state_next = TRIG_IDLE;
    endcase
    if (restart) begin
      state_next = TRIG_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRIG_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      idx <= 2'd0;
    end else if (state == TRIG_RUN && last_step && idx != 2'd2) begin
      idx <= idx + 2'd1;
    end
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (state == TRIG_LOAD) begin
      cx   <= CORDIC_GAIN;
      cy   <= '0;
      cz   <= ZW'({cur[13:0], 16'b0});
      step <= '0;
    end else if (state == TRIG_RUN) begin
      cx   <= x_next;
      cy   <= y_next;
      cz   <= z_next;
      step <= step + 5'd1;
    end
  end

  // quadrant fold and store
  always_ff @(posedge clk) begin
    if (state == TRIG_RUN && last_step && !restart) begin
      case (cur[15:14])
        2'd0: begin trig[idx].c <= x_next;  trig[idx].s <= y_next;  end
        2'd1: begin trig[idx].c <= -y_next; trig[idx].s <= x_next;  end
        2'd2: begin trig[idx].c <= -x_next; trig[idx].s <= -y_next; end
        default: begin trig[idx].c <= y_next; trig[idx].s <= -x_next; end
      endcase
    end
  end

endmodule

### design/erot_rot.sv
module erot_rot #(
  parameter erot_pkg::axis_t AXIS = erot_pkg::AXIS_X
) (
  input  logic             clk,
  input  logic             rst,
  input  erot_pkg::trig_t  cs,
  input  erot_pkg::stage_t din,
  output erot_pkg::stage_t dout
);
  import erot_pkg::*;

  work_t                  a;
  work_t                  b;
  stage_t                 mid;
  logic signed [ProdW-1:0] p_ca;
  logic signed [ProdW-1:0] p_sb;
  logic signed [ProdW-1:0] p_sa;
  logic signed [ProdW-1:0] p_cb;
  logic signed [SumW-1:0]  sum0;
  logic signed [SumW-1:0]  sum1;
  work_t                  t0;
  work_t                  t1;
  stage_t                 res;

  // pick the plane of rotation
  always_comb begin
    case (AXIS)
      AXIS_X:  begin a = din.y; b = din.z; end
      AXIS_Y:  begin a = din.z; b = din.x; end
      default: begin a = din.x; b = din.y; end
    endcase
  end

  // products stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else begin
      mid.valid <= din.valid;
    end
    mid.op <= din.op;
    mid.x  <= din.x;
    mid.y  <= din.y;
    mid.z  <= din.z;
    p_ca   <= ProdW'(cs.c) * ProdW'(a);
    p_sb   <= ProdW'(cs.s) * ProdW'(b);
    p_sa   <= ProdW'(cs.s) * ProdW'(a);
    p_cb   <= ProdW'(cs.c) * ProdW'(b);
  end

  // sum and round half up
  always_comb begin
    sum0 = SumW'(p_ca) - SumW'(p_sb) + (SumW'(1) <<< (FracW - 1));
    sum1 = SumW'(p_sa) + SumW'(p_cb) + (SumW'(1) <<< (FracW - 1));
    t0   = sum0[FracW+WorkW-1:FracW];
    t1   = sum1[FracW+WorkW-1:FracW];
    res  = mid;
    case (AXIS)
      AXIS_X:  begin res.y = t0; res.z = t1; end
      AXIS_Y:  begin res.z = t0; res.x = t1; end
      default: begin res.x = t0; res.y = t1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= res.valid;
    end
    dout.op <= res.op;
    dout.x  <= res.x;
    dout.y  <= res.y;
    dout.z  <= res.z;
  end

endmodule

### design/euler_rigid_transform.sv
// channel   ports                                      handshake
// config    cfg_write cfg_index cfg_data               write when cfg_write high
// input     op in_x in_y in_z                          taken when start & !busy
// result    out_x out_y out_z saturated                shown one cycle with done
//
// one item per cycle while busy is low; results come out in the order taken
// sine and cosine come from one iterative cordic, one angle after another
// busy is high after reset or an angle write until all three angles are done
// rst is synchronous; it clears the valid bits and the offset and angle registers
// the receiver cannot stall, so the pipeline never holds
module euler_rigid_transform (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [23:0]              cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  erot_pkg::coord_t         in_x,
  input  erot_pkg::coord_t         in_y,
  input  erot_pkg::coord_t         in_z,
  output logic                     done,
  output erot_pkg::coord_t         out_x,
  output erot_pkg::coord_t         out_y,
  output erot_pkg::coord_t         out_z,
  output logic                     saturated
);
  import erot_pkg::*;

  coord_t          offset [3];
  angle_t [2:0]    angle;
  trig_t  [2:0]    trig;
  logic            restart;
  stage_t          s_in;
  stage_t          s_roll;
  stage_t          s_pitch;
  stage_t          s_yaw;
  logic signed [WorkW:0] sum [3];
  coord_t          clip [3];
  logic [2:0]      clipped;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset[0] <= '0;
      offset[1] <= '0;
      offset[2] <= '0;
      angle     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OFFSET_X: offset[0] <= cfg_data;
        REG_OFFSET_Y: offset[1] <= cfg_data;
        REG_OFFSET_Z: offset[2] <= cfg_data;
        REG_ROLL:     angle[0]  <= cfg_data[AngleW-1:0];
        REG_PITCH:    angle[1]  <= cfg_data[AngleW-1:0];
        REG_YAW:      angle[2]  <= cfg_data[AngleW-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_write &&
                   (cfg_index == REG_ROLL || cfg_index == REG_PITCH ||
                    cfg_index == REG_YAW);

  erot_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .angle   (angle),
    .trig    (trig),
    .busy    (busy)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_in.valid <= 1'b0;
    end else begin
      s_in.valid <= start && !busy;
    end
    s_in.op <= op;
    s_in.x  <= WorkW'(in_x);
    s_in.y  <= WorkW'(in_y);
    s_in.z  <= WorkW'(in_z);
  end

  erot_rot #(.AXIS(AXIS_X)) u_roll (
    .clk (clk), .rst (rst), .cs (trig[0]), .din (s_in), .dout (s_roll)
  );

  erot_rot #(.AXIS(AXIS_Y)) u_pitch (
    .clk (clk), .rst (rst), .cs (trig[1]), .din (s_roll), .dout (s_pitch)
  );

  erot_rot #(.AXIS(AXIS_Z)) u_yaw (
    .clk (clk), .rst (rst), .cs (trig[2]), .din (s_pitch), .dout (s_yaw)
  );

  // translate and clamp
  always_comb begin
    sum[0] = (WorkW+1)'(s_yaw.x) + (s_yaw.op ? (WorkW+1)'(offset[0]) : '0);
    sum[1] = (WorkW+1)'(s_yaw.y) + (s_yaw.op ? (WorkW+1)'(offset[1]) : '0);
    sum[2] = (WorkW+1)'(s_yaw.z) + (s_yaw.op ? (WorkW+1)'(offset[2]) : '0);
    for (int k = 0; k < 3; k++) begin
      if (sum[k] > (WorkW+1)'(8388607)) begin
        clip[k]    = 24'sh7FFFFF;
        clipped[k] = 1'b1;
      end else if (sum[k] < -(WorkW+1)'(8388608)) begin
        clip[k]    = 24'sh800000;
        clipped[k] = 1'b1;
      end else begin
        clip[k]    = sum[k][CoordW-1:0];
        clipped[k] = 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_yaw.valid;
    end
    out_x     <= clip[0];
    out_y     <= clip[1];
    out_z     <= clip[2];
    saturated <= |clipped;
  end

endmodule

### test/tb_euler_rigid_transform.sv
`timescale 1ns / 100ps

module tb_euler_rigid_transform;
  import erot_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam int QUIET_CYCLES = 16;
  localparam longint ATAN_TURN[Steps] = '{
    536870912, 316933406, 167458908, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  typedef enum logic [1:0] {ENT_POINT, ENT_WRITE, ENT_DRAIN} ent_kind_t;

  typedef struct {
    ent_kind_t          kind;
    logic               op;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic [CfgIdxW-1:0] idx;
    logic [23:0]        data;
  } entry_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } pose_t;

  logic clk, rst, cfg_write, start, busy, op, done, saturated;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;
  coord_t in_x, in_y, in_z, out_x, out_y, out_z;

  euler_rigid_transform u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy), .op(op),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .done(done),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
  );

  // predictor copy of the registers
  coord_t mdl_off [3];
  angle_t mdl_ang [3];

  entry_t work_q[$];
  pose_t  pose_q[$];
  entry_t cur_item;
  bit     item_took;
  int unsigned quiet, gap, burst;
  int unsigned n_items, n_checked, n_sat, n_errors;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // cosine and sine of a binary angle, Q30, cordic plus quadrant fold
  task automatic sin_cos(input angle_t a, output longint co, output longint si);
    longint x, y, z, dx, dy;
    x = 652032875;
    y = 0;
    z = longint'(a[13:0]) << 16;
    for (int i = 0; i < Steps; i++) begin
      dx = x; dy = y;
      dx = dy >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    case (a[15:14])
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endtask

  function automatic longint mac_rnd(longint c1, longint a, longint c2, longint b);
    return (c1 * a + c2 * b + (longint'(1) << 29)) >>> 30;
  endfunction

  // roll, pitch, yaw, then optional translation and clamp
  task automatic transform_point(input entry_t e, output pose_t p);
    longint x, y, z, c, s, t0, t1;
    longint r[3];
    x = e.x; y = e.y; z = e.z;
    sin_cos(mdl_ang[0], c, s);
    t0 = mac_rnd(c, y, -s, z); t1 = mac_rnd(s, y, c, z);
    y = t0; z = t1;
    sin_cos(mdl_ang[1], c, s);
    t0 = mac_rnd(c, x, s, z); t1 = mac_rnd(-s, x, c, z);
    x = t0; z = t1;
    sin_cos(mdl_ang[2], c, s);
    t0 = mac_rnd(c, x, -s, y); t1 = mac_rnd(s, x, c, y);
    x = t0; y = t1;
    r[0] = x; r[1] = y; r[2] = z;
    p.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (e.op) r[k] += longint'(mdl_off[k]);
      if (r[k] > 8388607) begin
        r[k] = 8388607; p.sat = 1'b1;
      end else if (r[k] < -8388608) begin
        r[k] = -8388608; p.sat = 1'b1;
      end
    end
    p.x = coord_t'(r[0]); p.y = coord_t'(r[1]); p.z = coord_t'(r[2]);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(int'($urandom_range(0, 511)) - 256);
      1: return $urandom_range(0, 1) ? coord_t'(24'sh7fffff - $urandom_range(0, 3))
                                     : coord_t'(24'sh800000 + $urandom_range(0, 3));
      2: return coord_t'(int'($urandom_range(0, 131071)) - 65536);
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic add_point(input logic o, input coord_t x, input coord_t y, input coord_t z);
    entry_t e;
    e.kind = ENT_POINT; e.op = o; e.x = x; e.y = y; e.z = z;
    e.idx = '0; e.data = '0;
    work_q.push_back(e);
  endtask

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [23:0] data);
    entry_t e;
    e = '{ENT_WRITE, 1'b0, '0, '0, '0, idx, data};
    work_q.push_back(e);
  endtask

  task automatic add_setting(input logic [23:0] ox, input logic [23:0] oy,
                             input logic [23:0] oz, input logic [15:0] ro,
                             input logic [15:0] pi, input logic [15:0] ya);
    add_write(REG_OFFSET_X, ox);
    add_write(REG_OFFSET_Y, oy);
    add_write(REG_OFFSET_Z, oz);
    // upper data bits must not reach the angle registers
    add_write(REG_ROLL,  {8'($urandom()), ro});
    add_write(REG_PITCH, {8'($urandom()), pi});
    add_write(REG_YAW,   {8'($urandom()), ya});
  endtask

  // driver: one entry at a time from the work queue
  always @(negedge clk) begin
    logic n_start, n_wr;
    n_start = 1'b0;
    n_wr = 1'b0;
    if (!rst) begin
      if (item_took) begin
        void'(work_q.pop_front());
        item_took = 1'b0;
      end
      if (gap > 0) begin
        gap--;
      end else if (work_q.size() > 0) begin
        case (work_q[0].kind)
          ENT_POINT: begin
            n_start = 1'b1;
            cur_item = work_q[0];
            op <= work_q[0].op;
            in_x <= work_q[0].x;
            in_y <= work_q[0].y;
            in_z <= work_q[0].z;
            if (burst > 0) burst--;
            if (burst == 0) begin
              burst = $urandom_range(1, 40);
              gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
            end
          end
          ENT_WRITE: begin
            if (!busy && !start && pose_q.size() == 0 && quiet >= QUIET_CYCLES) begin
              n_wr = 1'b1;
              cfg_index <= work_q[0].idx;
              cfg_data <= work_q[0].data;
              if (work_q[0].idx < 3)
                mdl_off[2'(work_q[0].idx)] = coord_t'(work_q[0].data);
              else if (work_q[0].idx < 6)
                mdl_ang[2'(work_q[0].idx - 3'd3)] = work_q[0].data[15:0];
              void'(work_q.pop_front());
            end
          end
          default: begin
            if (pose_q.size() == 0) void'(work_q.pop_front());
          end
        endcase
      end
    end
    start <= n_start;
    cfg_write <= n_wr;
  end

  // monitor: log accepted items, check results in order
  always @(posedge clk) begin
    pose_t want, got;
    if (!rst) begin
      if (done) begin
        got = '{out_x, out_y, out_z, saturated};
        if (pose_q.size() == 0) begin
          $display("%0t: result with no item pending x=%0d y=%0d z=%0d sat=%0b",
                   $time, got.x, got.y, got.z, got.sat);
          n_errors++;
        end else begin
          want = pose_q.pop_front();
          n_checked++;
          if (got.sat) n_sat++;
          if (got.x !== want.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
            n_errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
            n_errors++;
          end
          if (got.z !== want.z) begin
            $display("%0t: out_z expected %0d actual %0d", $time, want.z, got.z);
            n_errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        transform_point(cur_item, want);
        pose_q.push_back(want);
        item_took = 1'b1;
        n_items++;
      end
      if (start || done || pose_q.size() > 0) quiet = 0;
      else quiet++;
    end
  end

  initial begin
    logic [23:0] ox, oy, oz;
    rst = 1'b1; cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    start = 1'b0; op = 1'b0; in_x = '0; in_y = '0; in_z = '0;
    item_took = 1'b0; quiet = 0; gap = 0; burst = 10;
    n_items = 0; n_checked = 0; n_sat = 0; n_errors = 0;
    for (int k = 0; k < 3; k++) begin
      mdl_off[k] = '0; mdl_ang[k] = '0;
    end

    // directed: reset registers, then field extremes under a mixed setting
    add_point(1'b1, 24'sh7fffff, 24'sh800000, 24'sd0);
    add_point(1'b0, 24'sh800000, 24'sh7fffff, -24'sd1);
    add_setting(24'h7fffff, 24'h800000, 24'h000100, 16'h8000, 16'h7fff, 16'h4000);
    add_write(REG_SPARE_LO, 24'hffffff);
    add_write(REG_SPARE_HI, 24'h123456);
    add_point(1'b0, 24'sd0, 24'sd0, 24'sd0);
    add_point(1'b1, 24'sd0, 24'sd0, 24'sd0);
    add_point(1'b1, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    add_point(1'b1, 24'sh800000, 24'sh800000, 24'sh800000);
    add_point(1'b0, 24'sh7fffff, 24'sh800000, 24'sh7fffff);
    add_point(1'b0, 24'sd256, -24'sd256, 24'sd1);
    add_point(1'b1, -24'sd1, -24'sd1, -24'sd1);
    add_point(1'b0, 24'sh555555, 24'shaaaaaa, 24'sh0f0f0f);
    // quarter turns and half turn
    add_setting(24'h000000, 24'h000000, 24'h000000, 16'hc000, 16'h4000, 16'h8000);
    add_point(1'b0, 24'sd1000, 24'sd2000, 24'sd3000);
    add_point(1'b1, 24'sh800000, 24'sd5, 24'sh7fffff);
    add_point(1'b0, 24'sh800000, 24'sh800000, 24'sh800000);
    add_setting(24'h800000, 24'h7fffff, 24'h800000, 16'h0001, 16'hffff, 16'h2000);
    add_point(1'b1, 24'sh7fffff, 24'sd0, 24'sh800000);
    add_point(1'b1, 24'sd0, 24'sh7fffff, 24'sd0);
    add_point(1'b0, 24'sd12345, -24'sd54321, 24'sd777);

    // random: fresh setting per phase, extremes now and then
    for (int ph = 0; ph < 8; ph++) begin
      ox = 24'($urandom()); oy = 24'($urandom()); oz = 24'($urandom());
      if (ph % 3 == 0) begin
        ox = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
        oz = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      end
      add_setting(ox, oy, oz, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      for (int n = 0; n < 175; n++) begin
        add_point(1'($urandom()), rand_coord(), rand_coord(), rand_coord());
        if (ph == 4 && n == 80) work_q.push_back('{ENT_DRAIN, 1'b0, '0, '0, '0, '0, '0});
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (work_q.size() == 0 && pose_q.size() == 0 && !start);
    repeat (30) @(posedge clk);
    $display("items accepted %0d, results checked %0d, saturated results %0d",
             n_items, n_checked, n_sat);
    $display("settings covered include half and quarter turns and offset extremes");
    if (n_errors == 0 && pose_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timeout after %0d items, %0d results", n_items, n_checked);
    $display("Verification failed");
    $finish;
  end

endmodule
